/* design/ctac_pkg.sv */
package ctac_pkg;

    // Field widths of the input and result items.
    localparam int unsigned TEMP_W      = 7;
    localparam int unsigned ALT_W       = 15;
    localparam int unsigned CORR_W      = 14;
    localparam int unsigned CALT_W      = 16;
    localparam int unsigned ROW_W       = 3;
    localparam int unsigned NUM_STEPS   = 13;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned STEP_W      = 12;
    localparam int unsigned ENTRY_W     = 10;
    localparam int unsigned ALT_LIMIT_DEF = 30000;

    // Largest possible correction, used by the checker.
    localparam int unsigned CORR_MAX    = 9700;

    typedef logic [NUM_STEPS-1:0][STEP_W-1:0]  t_step_vals;
    typedef logic [NUM_STEPS-1:0][ENTRY_W-1:0] t_row_vals;

    // Breakpoints in feet, index 0 is the smallest.
    localparam t_step_vals STEP_FT = {
        12'd3000, 12'd2000, 12'd1500, 12'd1000, 12'd900, 12'd800, 12'd700,
        12'd600, 12'd500, 12'd400, 12'd300, 12'd200, 12'd100
    };

    // Correction rows for 0, -10, -20, -30, -40 and -50 degrees Celsius.
    localparam t_row_vals CORR_ROW0 = {
        10'd170, 10'd120, 10'd90, 10'd60, 10'd50, 10'd50, 10'd40,
        10'd40, 10'd30, 10'd30, 10'd20, 10'd20, 10'd10
    };
    localparam t_row_vals CORR_ROW1 = {
        10'd290, 10'd200, 10'd150, 10'd100, 10'd90, 10'd80, 10'd70,
        10'd60, 10'd50, 10'd40, 10'd30, 10'd20, 10'd10
    };
    localparam t_row_vals CORR_ROW2 = {
        10'd420, 10'd280, 10'd210, 10'd140, 10'd130, 10'd120, 10'd100,
        10'd90, 10'd70, 10'd60, 10'd50, 10'd30, 10'd20
    };
    localparam t_row_vals CORR_ROW3 = {
        10'd570, 10'd380, 10'd280, 10'd190, 10'd170, 10'd150, 10'd140,
        10'd120, 10'd100, 10'd80, 10'd60, 10'd40, 10'd30
    };
    localparam t_row_vals CORR_ROW4 = {
        10'd720, 10'd480, 10'd360, 10'd240, 10'd220, 10'd190, 10'd170,
        10'd150, 10'd120, 10'd100, 10'd80, 10'd50, 10'd30
    };
    localparam t_row_vals CORR_ROW5 = {
        10'd890, 10'd590, 10'd450, 10'd300, 10'd270, 10'd240, 10'd210,
        10'd180, 10'd150, 10'd120, 10'd90, 10'd60, 10'd40
    };

    // Supported temperature steps.
    localparam logic signed [TEMP_W-1:0] TEMP_0   = 7'sd0;
    localparam logic signed [TEMP_W-1:0] TEMP_M10 = -7'sd10;
    localparam logic signed [TEMP_W-1:0] TEMP_M20 = -7'sd20;
    localparam logic signed [TEMP_W-1:0] TEMP_M30 = -7'sd30;
    localparam logic signed [TEMP_W-1:0] TEMP_M40 = -7'sd40;
    localparam logic signed [TEMP_W-1:0] TEMP_M50 = -7'sd50;

    typedef struct packed {
        logic             ok;
        logic [ROW_W-1:0] row;
    } t_temp_sel;

    // Command and status between controller and datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_stat;

    // Maps a temperature to its table row.
    function automatic t_temp_sel temp_select(input logic signed [TEMP_W-1:0] t);
        t_temp_sel sel;
        sel = '{ok: 1'b1, row: '0};
        if (t == TEMP_0) begin
            sel.row = 3'd0;
        end else if (t == TEMP_M10) begin
            sel.row = 3'd1;
        end else if (t == TEMP_M20) begin
            sel.row = 3'd2;
        end else if (t == TEMP_M30) begin
            sel.row = 3'd3;
        end else if (t == TEMP_M40) begin
            sel.row = 3'd4;
        end else if (t == TEMP_M50) begin
            sel.row = 3'd5;
        end else begin
            sel.ok = 1'b0;
        end
        return sel;
    endfunction

    // Correction entry for one row and one breakpoint.
    function automatic logic [ENTRY_W-1:0] corr_entry(input logic [ROW_W-1:0] row,
                                                      input logic [IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] val;
        case (row)
            3'd0:    val = CORR_ROW0[idx];
            3'd1:    val = CORR_ROW1[idx];
            3'd2:    val = CORR_ROW2[idx];
            3'd3:    val = CORR_ROW3[idx];
            3'd4:    val = CORR_ROW4[idx];
            3'd5:    val = CORR_ROW5[idx];
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* design/ctac_ifs.sv */
// Input channel: one temperature and altitude per transfer.
interface ctac_in_if import ctac_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_c;
    logic [ALT_W-1:0]         altitude_ft;

    modport source (output valid, temperature_c, altitude_ft, input ready);
    modport sink (input valid, temperature_c, altitude_ft, output ready);
endinterface

// Result channel: correction, corrected altitude and status per transfer.
interface ctac_out_if import ctac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CORR_W-1:0] correction_ft;
    logic [CALT_W-1:0] corrected_altitude_ft;
    logic              status;

    modport source (output valid, correction_ft, corrected_altitude_ft, status,
                    input ready);
    modport sink (input valid, correction_ft, corrected_altitude_ft, status,
                  output ready);
endinterface

/* design/ctac_dp.sv */
module ctac_dp import ctac_pkg::*; #(
    parameter int unsigned ALTITUDE_LIMIT = ALT_LIMIT_DEF
) (
    input  logic                     i_clk,
    input  logic signed [TEMP_W-1:0] i_temperature_c,
    input  logic [ALT_W-1:0]         i_altitude_ft,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    output logic [CORR_W-1:0]        o_correction_ft,
    output logic [CALT_W-1:0]        o_corrected_altitude_ft,
    output logic                     o_status
);

    logic [ALT_W-1:0]  r_rem,  n_rem;
    logic [IDX_W-1:0]  r_idx,  n_idx;
    logic [CORR_W-1:0] r_corr, n_corr;
    logic [ALT_W-1:0]  r_alt;
    logic [ROW_W-1:0]  r_row;
    logic              r_bad;
    logic [CORR_W-1:0] r_out_corr;
    logic [CALT_W-1:0] r_out_calt;
    logic              r_out_status;

    t_temp_sel          sel;
    logic [STEP_W-1:0]  step_ft;
    logic               take;

    assign sel     = temp_select(i_temperature_c);
    assign step_ft = STEP_FT[r_idx];
    assign take    = ({{(ALT_W-STEP_W){1'b0}}, step_ft} <= r_rem);

    // Done when the temperature is unsupported or less than the smallest step is left.
    assign o_stat.done = r_bad || ((r_idx == '0) && !take);

    // Load saturates the altitude; each step either takes one piece or moves down a breakpoint.
    always_comb begin
        n_rem  = r_rem;
        n_idx  = r_idx;
        n_corr = r_corr;
        if (i_cmd.load) begin
            n_idx  = IDX_W'(NUM_STEPS - 1);
            n_corr = '0;
            if ({2'b00, i_altitude_ft} > 17'(ALTITUDE_LIMIT)) begin
                n_rem = ALT_W'(ALTITUDE_LIMIT);
            end else begin
                n_rem = i_altitude_ft;
            end
        end else if (i_cmd.step) begin
            if (take) begin
                n_rem  = r_rem - {{(ALT_W-STEP_W){1'b0}}, step_ft};
                n_corr = r_corr + {{(CORR_W-ENTRY_W){1'b0}}, corr_entry(r_row, r_idx)};
            end else if (r_idx != '0) begin
                n_idx = r_idx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_idx  <= n_idx;
        r_corr <= n_corr;
        if (i_cmd.load) begin
            r_alt <= i_altitude_ft;
            r_row <= sel.row;
            r_bad <= !sel.ok;
        end
    end

    // Result register, loaded when the controller hands the item on.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_corr   <= r_corr;
            r_out_calt   <= {1'b0, r_alt} + {{(CALT_W-CORR_W){1'b0}}, r_corr};
            r_out_status <= r_bad;
        end
    end

    assign o_correction_ft         = r_out_corr;
    assign o_corrected_altitude_ft = r_out_calt;
    assign o_status                = r_out_status;

endmodule

/* design/ctac_ctrl.sv */
module ctac_ctrl import ctac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state, datapath commands and result valid.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_stat.done) begin
                    o_cmd.step = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/cold_temperature_altitude_correction_top.sv */
// Cold-temperature altimeter correction.
// Input channel i_in carries a temperature in Celsius and an indicated altitude
// in feet; result channel o_out returns the total correction, the corrected
// altitude and a status (1 when the temperature is not 0, -10, ..., -50).
// Both channels transfer on a rising edge with valid and ready high.
// A transfer on i_in loads the datapath, which then walks the breakpoints
// from 3000 ft down to 100 ft, one step per cycle: each step either takes
// one piece of the altitude or moves to the next smaller breakpoint.
// An item with an unsupported temperature skips this search.
// When the search finishes, the result enters the output register as soon as
// that register is empty or its result is taken, and is offered on o_out.
// Results sit in an output register, so the next item is accepted and worked
// on while the previous result waits; a stalled receiver only holds the
// finished item back from entering that register.
// Reset (i_rst_n low, synchronous) empties both channels and returns the
// controller to idle; no table or memory needs clearing.
module cold_temperature_altitude_correction_top import ctac_pkg::*; #(
    parameter int unsigned ALTITUDE_LIMIT = ALT_LIMIT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    ctac_in_if.sink    i_in,
    ctac_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer for the greedy breakpoint search.
    ctac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Remainder, breakpoint index and correction accumulator.
    ctac_dp #(
        .ALTITUDE_LIMIT (ALTITUDE_LIMIT)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_temperature_c         (i_in.temperature_c),
        .i_altitude_ft           (i_in.altitude_ft),
        .i_cmd                   (cmd),
        .o_stat                  (stat),
        .o_correction_ft         (o_out.correction_ft),
        .o_corrected_altitude_ft (o_out.corrected_altitude_ft),
        .o_status                (o_out.status)
    );

endmodule

/* design/ctac_checker.sv */
module ctac_checker import ctac_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CORR_W-1:0] i_correction_ft,
    input logic [CALT_W-1:0] i_corrected_altitude_ft,
    input logic              i_status
);

    // A result that is offered stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    // An unsupported temperature gives no correction.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_correction_ft == '0)
        else $error("nonzero correction with bad status");

    // The corrected altitude includes the correction and never wraps.
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_corrected_altitude_ft >= {2'b00, i_correction_ft})
        else $error("corrected altitude below correction");

    // The correction stays within CORR_MAX, the largest possible correction.
    a_corr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_correction_ft <= CORR_W'(CORR_MAX))
        else $error("correction out of range");

    // A new result never appears at the edge right after an input transfer.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared too early");

endmodule

bind cold_temperature_altitude_correction_top ctac_checker u_ctac_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .i_in_valid              (i_in.valid),
    .i_in_ready              (i_in.ready),
    .i_out_valid             (o_out.valid),
    .i_out_ready             (o_out.ready),
    .i_correction_ft         (o_out.correction_ft),
    .i_corrected_altitude_ft (o_out.corrected_altitude_ft),
    .i_status                (o_out.status)
);
